### hdl/jstd_pkg.sv
// ----------------------------------------------------------------------------
// JSON string token decoder: shared definitions
// Phase codes, result status codes, character constants and the word
// structures that pass between the decoder core, the output queue and the
// top level.
// ----------------------------------------------------------------------------
package jstd_pkg;

	// Decoder phase, one-hot.
	typedef enum logic [7:0] {
		PH_IDLE     = 8'b0000_0001,
		PH_STR      = 8'b0000_0010,
		PH_ESC      = 8'b0000_0100,
		PH_HEX1     = 8'b0000_1000,
		PH_WANT_BSL = 8'b0001_0000,
		PH_WANT_U   = 8'b0010_0000,
		PH_HEX2     = 8'b0100_0000,
		PH_UTF8     = 8'b1000_0000
	} phase_t;

	// Result status codes.
	localparam logic [1:0] ST_UNIT = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// Characters of interest.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_ASCII_END = 8'h80;

	localparam logic [15:0] SURR_HI_LO = 16'hD800;
	localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LO_LO = 16'hDC00;
	localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
	localparam logic [20:0] SCALAR_MAX = 21'h10FFFF;
	localparam logic [20:0] PLANE1     = 21'h010000;

	// Output queue depth and its index and count widths.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [15:0] code_unit;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// Up to two results caused by one input word.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} step_out_t;

	// Hex digit value: bit 4 set when the byte is a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		v = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			v = {1'b1, b[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

### hdl/jstd_core.sv
// ----------------------------------------------------------------------------
// JSON string token decoder: decoder core
// Holds the token state and decodes one registered input word per step
// into zero, one or two results.
// ----------------------------------------------------------------------------
module jstd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 mode,
	input  logic [7:0]           byte_value,
	output jstd_pkg::step_out_t  res
);

	jstd_pkg::phase_t phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  hexcnt_q, hexcnt_d;
	logic [15:0] held_q, held_d;
	logic [20:0] utf_q, utf_d;
	logic [1:0]  utfrem_q, utfrem_d;

	logic        err;
	logic        done;
	logic [1:0]  n_units;
	logic [15:0] u0, u1;
	logic [4:0]  hv;
	logic [15:0] hex_cat;
	logic [20:0] utf_cat;
	logic [20:0] scal_off;
	logic [7:0]  b;

	assign b        = byte_value;
	assign hv       = jstd_pkg::hex_val(b);
	assign hex_cat  = {hex_q[11:0], hv[3:0]};
	assign utf_cat  = {utf_q[14:0], b[5:0]};
	assign scal_off = utf_cat - jstd_pkg::PLANE1;

	always_comb begin
		phase_d  = phase_q;
		hex_d    = hex_q;
		hexcnt_d = hexcnt_q;
		held_d   = held_q;
		utf_d    = utf_q;
		utfrem_d = utfrem_q;
		err      = 1'b0;
		done     = 1'b0;
		n_units  = 2'd0;
		u0       = 16'd0;
		u1       = 16'd0;
		if (step) begin
			if (mode) begin
				err = (phase_q != jstd_pkg::PH_IDLE);
			end else begin
				case (phase_q)
					jstd_pkg::PH_IDLE: begin
						if (b == jstd_pkg::CH_QUOTE) begin
							phase_d = jstd_pkg::PH_STR;
						end else if (b != jstd_pkg::CH_SPACE && b != jstd_pkg::CH_TAB &&
								b != jstd_pkg::CH_LF && b != jstd_pkg::CH_CR) begin
							err = 1'b1;
						end
					end
					jstd_pkg::PH_STR: begin
						if (b == jstd_pkg::CH_QUOTE) begin
							done = 1'b1;
						end else if (b == jstd_pkg::CH_BSL) begin
							phase_d = jstd_pkg::PH_ESC;
						end else if (b < jstd_pkg::CH_SPACE) begin
							err = 1'b1;
						end else if (b < jstd_pkg::CH_ASCII_END) begin
							n_units = 2'd1;
							u0      = {8'h00, b};
						end else if (b[7:5] == 3'b110) begin
							utf_d    = {16'd0, b[4:0]};
							utfrem_d = 2'd1;
							phase_d  = jstd_pkg::PH_UTF8;
						end else if (b[7:4] == 4'b1110) begin
							utf_d    = {17'd0, b[3:0]};
							utfrem_d = 2'd2;
							phase_d  = jstd_pkg::PH_UTF8;
						end else if (b[7:3] == 5'b11110) begin
							utf_d    = {18'd0, b[2:0]};
							utfrem_d = 2'd3;
							phase_d  = jstd_pkg::PH_UTF8;
						end else begin
							err = 1'b1;
						end
					end
					jstd_pkg::PH_ESC: begin
						phase_d = jstd_pkg::PH_STR;
						n_units = 2'd1;
						case (b)
							jstd_pkg::CH_QUOTE, jstd_pkg::CH_BSL,
							jstd_pkg::CH_SLASH: u0 = {8'h00, b};
							jstd_pkg::CH_B: u0 = 16'h0008;
							jstd_pkg::CH_F: u0 = 16'h000C;
							jstd_pkg::CH_N: u0 = 16'h000A;
							jstd_pkg::CH_R: u0 = 16'h000D;
							jstd_pkg::CH_T: u0 = 16'h0009;
							jstd_pkg::CH_U: begin
								n_units  = 2'd0;
								phase_d  = jstd_pkg::PH_HEX1;
								hex_d    = 16'd0;
								hexcnt_d = 2'd0;
							end
							default: begin
								n_units = 2'd0;
								err     = 1'b1;
							end
						endcase
					end
					jstd_pkg::PH_HEX1, jstd_pkg::PH_HEX2: begin
						if (!hv[4]) begin
							err = 1'b1;
						end else if (hexcnt_q != 2'd3) begin
							hex_d    = hex_cat;
							hexcnt_d = hexcnt_q + 2'd1;
						end else if (phase_q == jstd_pkg::PH_HEX1) begin
							hexcnt_d = 2'd0;
							hex_d    = 16'd0;
							if (hex_cat >= jstd_pkg::SURR_HI_LO &&
									hex_cat <= jstd_pkg::SURR_HI_HI) begin
								held_d  = hex_cat;
								phase_d = jstd_pkg::PH_WANT_BSL;
							end else if (hex_cat >= jstd_pkg::SURR_LO_LO &&
									hex_cat <= jstd_pkg::SURR_LO_HI) begin
								err = 1'b1;
							end else begin
								phase_d = jstd_pkg::PH_STR;
								n_units = 2'd1;
								u0      = hex_cat;
							end
						end else begin
							if (hex_cat < jstd_pkg::SURR_LO_LO ||
									hex_cat > jstd_pkg::SURR_LO_HI) begin
								err = 1'b1;
							end else begin
								hexcnt_d = 2'd0;
								hex_d    = 16'd0;
								held_d   = 16'd0;
								phase_d  = jstd_pkg::PH_STR;
								n_units  = 2'd2;
								u0       = held_q;
								u1       = hex_cat;
							end
						end
					end
					jstd_pkg::PH_WANT_BSL: begin
						if (b != jstd_pkg::CH_BSL) begin
							err = 1'b1;
						end else begin
							phase_d = jstd_pkg::PH_WANT_U;
						end
					end
					jstd_pkg::PH_WANT_U: begin
						if (b != jstd_pkg::CH_U) begin
							err = 1'b1;
						end else begin
							phase_d  = jstd_pkg::PH_HEX2;
							hex_d    = 16'd0;
							hexcnt_d = 2'd0;
						end
					end
					jstd_pkg::PH_UTF8: begin
						if (b[7:6] != 2'b10) begin
							err = 1'b1;
						end else if (utfrem_q > 2'd1) begin
							utf_d    = utf_cat;
							utfrem_d = utfrem_q - 2'd1;
						end else if (utf_cat > jstd_pkg::SCALAR_MAX) begin
							err = 1'b1;
						end else begin
							utf_d    = 21'd0;
							utfrem_d = 2'd0;
							phase_d  = jstd_pkg::PH_STR;
							if (utf_cat >= jstd_pkg::PLANE1) begin
								// Supplementary plane: split into a surrogate pair.
								n_units = 2'd2;
								u0      = {6'b110110, scal_off[19:10]};
								u1      = {6'b110111, scal_off[9:0]};
							end else begin
								n_units = 2'd1;
								u0      = utf_cat[15:0];
							end
						end
					end
					default: begin
						phase_d = jstd_pkg::PH_IDLE;
					end
				endcase
			end
			if (err || done) begin
				phase_d  = jstd_pkg::PH_IDLE;
				hex_d    = 16'd0;
				hexcnt_d = 2'd0;
				held_d   = 16'd0;
				utf_d    = 21'd0;
				utfrem_d = 2'd0;
			end
		end
	end

	always_comb begin
		res = '0;
		if (err || done) begin
			res.count     = 2'd1;
			res.r0.status = err ? jstd_pkg::ST_ERR : jstd_pkg::ST_DONE;
			res.r0.last   = 1'b1;
		end else begin
			res.count        = n_units;
			res.r0.code_unit = u0;
			res.r0.status    = jstd_pkg::ST_UNIT;
			res.r0.last      = (n_units == 2'd1);
			res.r1.code_unit = u1;
			res.r1.status    = jstd_pkg::ST_UNIT;
			res.r1.last      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= jstd_pkg::PH_IDLE;
			hex_q    <= 16'd0;
			hexcnt_q <= 2'd0;
			held_q   <= 16'd0;
			utf_q    <= 21'd0;
			utfrem_q <= 2'd0;
		end else begin
			phase_q  <= phase_d;
			hex_q    <= hex_d;
			hexcnt_q <= hexcnt_d;
			held_q   <= held_d;
			utf_q    <= utf_d;
			utfrem_q <= utfrem_d;
		end
	end

`ifndef NO_ASSERTIONS
	// Idle is only reached through a full clear of the accumulators.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == jstd_pkg::PH_IDLE) |-> (hexcnt_q == 2'd0 && utfrem_q == 2'd0 &&
			held_q == 16'd0))
		else $error("accumulators not clear while idle");

	// A pair of code units only comes out of a low surrogate or a four-byte sequence.
	a_pair_src: assert property (@(posedge clk) disable iff (!arst_n)
		(res.count == 2'd2) |-> (phase_q == jstd_pkg::PH_HEX2 ||
			phase_q == jstd_pkg::PH_UTF8))
		else $error("surrogate pair from unexpected phase");

	// A held high surrogate exists only while waiting for its partner.
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != 16'd0) |-> (phase_q == jstd_pkg::PH_WANT_BSL ||
			phase_q == jstd_pkg::PH_WANT_U || phase_q == jstd_pkg::PH_HEX2))
		else $error("high surrogate held outside its wait phases");
`endif

endmodule

### hdl/jstd_outq.sv
// ----------------------------------------------------------------------------
// JSON string token decoder: result queue
// Small register queue that takes up to two results per cycle and hands
// them out one word at a time on the master side.
// ----------------------------------------------------------------------------
module jstd_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jstd_pkg::step_out_t  res,
	output logic                 room,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,    // code_unit
	output logic [1:0]           m_tuser,    // status
	output logic                 m_tlast
);

	jstd_pkg::res_t                 mem_q [jstd_pkg::QDEPTH];
	logic [jstd_pkg::QAW-1:0]       wr_q, rd_q;
	logic [jstd_pkg::QCW-1:0]       cnt_q;
	logic [1:0]                     n_push;
	logic                           pop;
	logic [jstd_pkg::QAW-1:0]       wr_nx;

	assign n_push   = push ? res.count : 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign wr_nx    = wr_q + 1'b1;
	// Room for a full pair, judged on the registered fill level.
	assign room     = (cnt_q <= jstd_pkg::QCW'(jstd_pkg::QDEPTH - 2));
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = mem_q[rd_q].code_unit;
	assign m_tuser  = mem_q[rd_q].status;
	assign m_tlast  = mem_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= res.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_nx] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + jstd_pkg::QAW'(n_push);
			rd_q  <= rd_q + jstd_pkg::QAW'(pop);
			cnt_q <= cnt_q + jstd_pkg::QCW'(n_push) - jstd_pkg::QCW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |-> room)
		else $error("result pushed without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && n_push == 2'd0) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("fill level wrong after pop");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= jstd_pkg::QCW'(jstd_pkg::QDEPTH))
		else $error("fill level above depth");
`endif

endmodule

### hdl/json_string_token_decoder.sv
// ----------------------------------------------------------------------------
// JSON string token decoder
// UTF-8 bytes of a JSON string token in, UTF-16 code units, done and error
// results out.
//
//   channel  | dir | tdata           | tuser          | tlast
//   ---------+-----+-----------------+----------------+------------------------
//   s_*      | in  | [7:0] byte      | [0] mode       | -
//   m_*      | out | [15:0] code unit| [1:0] status   | final result of a word
//
// One input word is taken per cycle while the input register is free or the
// queue has room for a pair; it is registered, decoded once the queue can
// hold a pair, and its results land in a four-entry queue. A surrogate pair
// leaves as two output words. The input stalls while the queue cannot hold
// a pair. Reset puts the decoder in idle with the queue empty.
// ----------------------------------------------------------------------------
module json_string_token_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // byte_value
	input  logic [0:0]  s_tuser,    // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // code_unit
	output logic [1:0]  m_tuser,    // status
	output logic        m_tlast
);

	logic                valid_s1;
	logic                mode_s1;
	logic [7:0]          byte_s1;
	logic                room;
	logic                advance;
	jstd_pkg::step_out_t res;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	jstd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.mode       (mode_s1),
		.byte_value (byte_s1),
		.res        (res)
	);

	jstd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
